// File: rtl/core/tdte_pkg.sv
// Package: word types and constants for the tagged decimal token extractor
`timescale 1ns / 1ps

package tdte_pkg;

   localparam int unsigned PrefixLen = 16;
   localparam int unsigned PrefixIdxW = $clog2(PrefixLen);
   localparam int unsigned MatchW = $clog2(PrefixLen + 1);
   localparam int unsigned ValueW = 31;
   localparam int unsigned ProdW = ValueW + 4;

   localparam logic [ValueW-1:0] VALUE_MAX = {ValueW{1'b1}};

   localparam logic [7:0] CHAR_LT = 8'h3C;
   localparam logic [7:0] CHAR_GT = 8'h3E;
   localparam logic [7:0] CHAR_BAR = 8'h7C;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [ValueW-1:0] token_value;
      logic              value_overflowed;
   } rsp_word_type;

   function automatic logic [7:0] prefix_char(input logic [PrefixIdxW-1:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h3C; // <
         4'd1:    c = 8'h7C; // |
         4'd2:    c = 8'h63; // c
         4'd3:    c = 8'h6F; // o
         4'd4:    c = 8'h6E; // n
         4'd5:    c = 8'h74; // t
         4'd6:    c = 8'h65; // e
         4'd7:    c = 8'h6E; // n
         4'd8:    c = 8'h74; // t
         4'd9:    c = 8'h5F; // _
         4'd10:   c = 8'h73; // s
         4'd11:   c = 8'h74; // t
         4'd12:   c = 8'h79; // y
         4'd13:   c = 8'h6C; // l
         4'd14:   c = 8'h65; // e
         default: c = 8'h5F; // _
      endcase
      return c;
   endfunction

endpackage

// File: rtl/core/tagged_decimal_token_extractor.sv
// Top level: tag prefix matcher and decimal body accumulator
`timescale 1ns / 1ps

// Usage
// req channel: one text byte per word with an end_of_text marker. A word is
//   taken at an edge where req_valid is high and req_stall is low.
// rsp channel: one word per well-formed tag (the fixed tag prefix, digits,
//   then "|>"), holding the decimal value, saturated at 2^31-1, and an
//   overflow flag. Tags with an empty or non-digit body give no word.
// Path: a word taken from req is held in the input register and worked on
//   from there; its result, if any, is then written to the result register.
// Throughput: one byte per cycle while no result is stalled; set by the
//   single state update per byte (multiply by ten, add, saturation check).
// Stall: while rsp_stall holds a pending result, the input register holds
//   its word and req_stall rises in the same cycle; an empty input
//   register still takes one word before the sender sees a stall.
// Reset: synchronous and active high; all matching state returns to
//   scanning for the prefix and both registers empty. After a byte marked
//   end_of_text the matching state also returns to scanning.
module tagged_decimal_token_extractor
   import tdte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam logic [1:0] PH_SCAN = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_BAR  = 2'd2;

   logic               in_valid_ff, in_valid_in;
   req_word_type       in_word_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic [MatchW-1:0]  match_ff, match_in;
   logic [1:0]         phase_ff, phase_in;
   logic               clean_ff, clean_in;
   logic               seen_ff, seen_in;
   logic [ValueW-1:0]  acc_ff, acc_in;
   logic               sat_ff, sat_in;

   logic               advance;
   logic               req_take;
   logic               emit;
   logic [7:0]         b;
   logic               is_digit;
   logic [ProdW-1:0]   prod;
   logic               prod_over;
   logic [MatchW-1:0]  m_cur;
   logic [MatchW-1:0]  m_next;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign b        = in_word_ff.text_byte;
   assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign prod     = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + {{(ProdW-4){1'b0}}, b[3:0]};
   assign prod_over = prod > {4'b0, VALUE_MAX};

   always_comb begin
      m_cur = (match_ff >= MatchW'(PrefixLen)) ? '0 : match_ff;
      if (b == prefix_char(m_cur[PrefixIdxW-1:0])) begin
         m_next = m_cur + 1'b1;
      end else if (b == CHAR_LT) begin
         m_next = MatchW'(1);
      end else begin
         m_next = '0;
      end
   end

   always_comb begin
      match_in = match_ff;
      phase_in = phase_ff;
      clean_in = clean_ff;
      seen_in  = seen_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      emit     = 1'b0;
      unique case (phase_ff)
         PH_SCAN: begin
            if (m_next == MatchW'(PrefixLen)) begin
               match_in = '0;
               phase_in = PH_BODY;
               clean_in = 1'b1;
               seen_in  = 1'b0;
               acc_in   = '0;
               sat_in   = 1'b0;
            end else begin
               match_in = m_next;
            end
         end
         PH_BODY, PH_BAR: begin
            if (phase_ff == PH_BAR && b == CHAR_GT) begin
               emit     = clean_ff && seen_ff;
               match_in = '0;
               phase_in = PH_SCAN;
               clean_in = 1'b1;
               seen_in  = 1'b0;
               acc_in   = '0;
               sat_in   = 1'b0;
            end else begin
               if (phase_ff == PH_BAR) begin
                  clean_in = 1'b0;
               end
               if (b == CHAR_BAR) begin
                  phase_in = PH_BAR;
               end else begin
                  phase_in = PH_BODY;
                  if (is_digit) begin
                     seen_in = 1'b1;
                     if (prod_over) begin
                        acc_in = VALUE_MAX;
                        sat_in = 1'b1;
                     end else begin
                        acc_in = prod[ValueW-1:0];
                     end
                  end else begin
                     clean_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            match_in = '0;
            phase_in = PH_SCAN;
         end
      endcase
      if (in_word_ff.end_of_text) begin
         match_in = '0;
         phase_in = PH_SCAN;
         clean_in = 1'b1;
         seen_in  = 1'b0;
         acc_in   = '0;
         sat_in   = 1'b0;
      end
   end

   always_comb begin
      rsp_word_in.token_value      = acc_ff;
      rsp_word_in.value_overflowed = sat_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         match_ff     <= '0;
         phase_ff     <= PH_SCAN;
         clean_ff     <= 1'b1;
         seen_ff      <= 1'b0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            match_ff <= match_in;
            phase_ff <= phase_in;
            clean_ff <= clean_in;
            seen_ff  <= seen_in;
            acc_ff   <= acc_in;
            sat_ff   <= sat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance && emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result raised without a byte worked on");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.value_overflowed |-> rsp_word_ff.token_value == VALUE_MAX)
      else $error("overflow flagged on an unsaturated value");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_SCAN |-> match_ff == '0)
      else $error("prefix count live inside a tag body");

   assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> acc_ff == VALUE_MAX && seen_ff)
      else $error("saturation flag without a saturated accumulator");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input held without a pending result");

endmodule

// File: dv/testbench.sv
// Testbench: directed and random text streams, checked against a tag value predictor
`timescale 1ns / 1ps

module testbench;
   import tdte_pkg::*;

   typedef enum logic [1:0] {SCAN_PREFIX, IN_BODY, AFTER_BAR} scan_phase_type;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   req_word_type   req_word;
   logic           rsp_valid;
   logic           rsp_stall;
   rsp_word_type   rsp_word;

   logic [4:0]     match_len;
   scan_phase_type scan_phase;
   logic           body_all_digits;
   logic           body_has_digit;
   logic [30:0]    token_acc;
   logic           acc_saturated;

   rsp_word_type   pending_tokens[$];
   int             error_count = 0;
   int             bytes_sent = 0;
   int             req_max_idle = 8;
   int             rsp_max_idle = 8;
   int             rsp_hold = 0;

   tagged_decimal_token_extractor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("TB_ERROR");
      $finish;
   end

   function void clear_scan_state();
      match_len = 5'd0;
      scan_phase = SCAN_PREFIX;
      body_all_digits = 1'b1;
      body_has_digit = 1'b0;
      token_acc = '0;
      acc_saturated = 1'b0;
   endfunction

   function void add_body_byte(input logic [7:0] b);
      logic [63:0] next_acc;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         next_acc = 64'(token_acc) * 64'd10 + 64'(b - CHAR_ZERO);
         body_has_digit = 1'b1;
         if (next_acc > 64'(VALUE_MAX)) begin
            token_acc = VALUE_MAX;
            acc_saturated = 1'b1;
         end else begin
            token_acc = next_acc[30:0];
         end
      end else begin
         body_all_digits = 1'b0;
      end
   endfunction

   function void decode_text_byte(input req_word_type w);
      logic [7:0]   b;
      int           m;
      rsp_word_type token;
      b = w.text_byte;
      case (scan_phase)
         SCAN_PREFIX: begin
            m = int'(match_len);
            if (m >= int'(PrefixLen)) m = 0;
            if (b == prefix_char(PrefixIdxW'(m))) m++;
            else if (b == CHAR_LT) m = 1;
            else m = 0;
            if (m == int'(PrefixLen)) begin
               clear_scan_state();
               scan_phase = IN_BODY;
            end else begin
               match_len = 5'(m);
            end
         end
         AFTER_BAR: begin
            if (b == CHAR_GT) begin
               if (body_all_digits && body_has_digit) begin
                  token.token_value = token_acc;
                  token.value_overflowed = acc_saturated;
                  pending_tokens.insert(pending_tokens.size(), token);
               end
               clear_scan_state();
            end else begin
               body_all_digits = 1'b0;
               if (b != CHAR_BAR) begin
                  scan_phase = IN_BODY;
                  add_body_byte(b);
               end
            end
         end
         default: begin
            if (b == CHAR_BAR) scan_phase = AFTER_BAR;
            else add_body_byte(b);
         end
      endcase
      if (w.end_of_text) clear_scan_state();
   endfunction

   always @(posedge clock) begin : word_monitor
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_tokens.size() == 0) begin
               $error("unexpected result word: token_value %0d, value_overflowed %0d",
                      rsp_word.token_value, rsp_word.value_overflowed);
               error_count++;
            end else begin
               want = pending_tokens.pop_front();
               if (rsp_word.token_value !== want.token_value) begin
                  $error("token_value: expected %0d, got %0d",
                         want.token_value, rsp_word.token_value);
                  error_count++;
               end
               if (rsp_word.value_overflowed !== want.value_overflowed) begin
                  $error("value_overflowed: expected %0d, got %0d",
                         want.value_overflowed, rsp_word.value_overflowed);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) decode_text_byte(req_word);
      end
   end

   initial begin : rsp_side
      int   stall_left;
      logic taken;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         taken = rsp_valid && !rsp_stall;
         @(negedge clock);
         if (rsp_hold != 0) begin
            stall_left = rsp_hold;
            rsp_hold = 0;
         end else if (taken) begin
            stall_left = $urandom_range(0, rsp_max_idle);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eot);
      int           gap;
      req_word_type w;
      gap = $urandom_range(0, req_max_idle);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      w.text_byte = b;
      w.end_of_text = eot;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic eot_at_end);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i], eot_at_end && i == s.len() - 1);
   endtask

   task automatic send_open(input int first, input int stop, input logic eot_at_end);
      int i;
      for (i = first; i < stop; i++)
         send_byte(prefix_char(PrefixIdxW'(i)), eot_at_end && i == stop - 1);
   endtask

   task automatic send_tag(input string body, input logic eot_at_end);
      send_open(0, int'(PrefixLen), 1'b0);
      send_text(body, eot_at_end);
   endtask

   task automatic send_prefix(input int bad_pos);
      int i;
      for (i = 0; i < int'(PrefixLen); i++) begin
         if (i == bad_pos)
            send_byte($urandom_range(0, 1) ? CHAR_LT : 8'($urandom_range(0, 255)), 1'b0);
         else
            send_byte(prefix_char(PrefixIdxW'(i)), 1'b0);
      end
   endtask

   task automatic send_digits(input int n);
      int i;
      for (i = 0; i < n; i++) send_byte(8'(CHAR_ZERO + $urandom_range(0, 9)), 1'b0);
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_tokens.size() != 0);
   endtask

   task automatic test_plain_tags;
      send_tag("0|>", 1'b0);
      send_tag("2147483647|>", 1'b0);
      send_text("x", 1'b0);
      send_tag("007|>y", 1'b0);
   endtask

   task automatic test_prefix_restart;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("<", 1'b0);
      send_tag("5|>", 1'b0);
      send_open(0, 6, 1'b0);
      send_tag("12|>", 1'b0);
      send_open(0, 14, 1'b0);
      send_text("X_3|>", 1'b0);
      send_open(0, int'(PrefixLen), 1'b0);
      send_tag("4|>|>", 1'b0);
   endtask

   task automatic test_body_rules;
      send_tag("|>", 1'b0);
      send_tag("1a2|>", 1'b0);
      send_tag("1|2|>", 1'b0);
      send_tag("12||>", 1'b0);
      send_prefix(-1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_text("|>", 1'b0);
      send_tag("86|>", 1'b0);
   endtask

   task automatic test_overflow;
      send_tag("2147483648|>", 1'b0);
      send_tag("99999999999999999999|>", 1'b0);
      send_tag("00002147483647|>", 1'b0);
   endtask

   task automatic test_end_of_text;
      send_tag("42", 1'b1);
      send_text("|>", 1'b0);
      send_tag("42|", 1'b1);
      send_text(">", 1'b0);
      send_tag("42|>", 1'b1);
      send_open(0, 13, 1'b1);
      send_open(13, int'(PrefixLen), 1'b0);
      send_text("7|>", 1'b0);
      send_tag("64|>", 1'b0);
   endtask

   task automatic test_backpressure;
      wait_drained();
      rsp_hold = 150;
      req_max_idle = 0;
      repeat (5) send_tag("31|>", 1'b0);
      wait_drained();
      req_max_idle = 8;
   endtask

   task automatic test_random_stream;
      int         stop_at;
      int         seq;
      int         n;
      int         i;
      logic [7:0] c;
      stop_at = bytes_sent + 560;
      seq = 0;
      while (bytes_sent < stop_at) begin
         if (seq % 30 == 0) begin
            req_max_idle = ($urandom_range(0, 2) == 0) ? 0 : 8;
            rsp_max_idle = ($urandom_range(0, 2) == 0) ? 0 : 8;
         end
         seq++;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               send_prefix(-1);
               if ($urandom_range(0, 7) == 0) send_digits($urandom_range(10, 14));
               else send_digits($urandom_range(1, 9));
               send_byte(CHAR_BAR, 1'b0);
               send_byte(CHAR_GT, $urandom_range(0, 7) == 0);
            end
            6: begin
               send_prefix($urandom_range(0, 15));
               send_digits($urandom_range(1, 4));
               send_byte(CHAR_BAR, 1'b0);
               send_byte(CHAR_GT, 1'b0);
            end
            7: begin
               send_prefix(-1);
               n = $urandom_range(0, 6);
               for (i = 0; i < n; i++) begin
                  case ($urandom_range(0, 3))
                     0:       c = 8'(CHAR_ZERO + $urandom_range(0, 9));
                     1:       c = CHAR_BAR;
                     2:       c = CHAR_LT;
                     default: c = 8'($urandom_range(0, 255));
                  endcase
                  send_byte(c, 1'b0);
               end
               send_byte(CHAR_BAR, 1'b0);
               send_byte(CHAR_GT, 1'b0);
            end
            8: begin
               n = $urandom_range(1, PrefixLen);
               send_open(0, n, 1'b0);
               if (n == int'(PrefixLen)) send_digits($urandom_range(0, 3));
               send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
               n = $urandom_range(1, 6);
               for (i = 0; i < n; i++)
                  send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      clear_scan_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_plain_tags();
      test_prefix_restart();
      test_body_rules();
      test_overflow();
      test_end_of_text();
      test_backpressure();
      test_random_stream();
      wait_drained();
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
